// ===== hw/rtl/skt_pkg.sv =====
package skt_pkg;

	localparam int KEY_W         = 16;
	localparam int YEAR_W        = 12;
	localparam int STATUS_W      = 3;
	localparam int ENTRY_COUNT_W = 5;

	typedef enum logic [STATUS_W-1:0] {
		ST_INSERTED  = 3'd0,
		ST_DUPLICATE = 3'd1,
		ST_REMOVED   = 3'd2,
		ST_NOT_FOUND = 3'd3,
		ST_FULL      = 3'd4
	} status_t;

	typedef enum logic {
		FUNC_INSERT = 1'b0,
		FUNC_DELETE = 1'b1
	} func_t;

	typedef struct packed {
		logic              valid;
		logic [KEY_W-1:0]  key;
		logic [YEAR_W-1:0] year;
	} entry_t;

	typedef struct packed {
		logic              cmp_en;
		logic              ins_en;
		logic              del_en;
		logic [KEY_W-1:0]  key;
		logic [YEAR_W-1:0] year;
	} cell_ctrl_t;

endpackage

// ===== hw/rtl/skt_cell.sv =====
module skt_cell (
	input  logic                clk,
	input  logic                arst_n,
	input  skt_pkg::cell_ctrl_t ctrl,
	input  skt_pkg::entry_t     left_entry,
	input  logic                left_lt,
	input  skt_pkg::entry_t     right_entry,
	output skt_pkg::entry_t     entry,
	output logic                lt,
	output logic                eq
);

	logic                       valid_q;
	logic [skt_pkg::KEY_W-1:0]  key_q;
	logic [skt_pkg::YEAR_W-1:0] year_q;
	logic                       lt_q;
	logic                       eq_q;
	skt_pkg::entry_t            next_entry;
	logic                       load;

	// entries at or past the command's slot move; the ones below hold
	always_comb begin
		next_entry = '{valid: valid_q, key: key_q, year: year_q};
		load       = 1'b0;
		if (ctrl.ins_en && !lt_q) begin
			load = 1'b1;
			if (left_lt) begin
				next_entry = '{valid: 1'b1, key: ctrl.key, year: ctrl.year};
			end else begin
				next_entry = left_entry;
			end
		end else if (ctrl.del_en && !lt_q) begin
			load       = 1'b1;
			next_entry = right_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			lt_q    <= 1'b0;
			eq_q    <= 1'b0;
		end else begin
			if (load) begin
				valid_q <= next_entry.valid;
			end
			if (ctrl.cmp_en) begin
				lt_q <= valid_q && (key_q < ctrl.key);
				eq_q <= valid_q && (key_q == ctrl.key);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			key_q  <= next_entry.key;
			year_q <= next_entry.year;
		end
	end

	assign entry = '{valid: valid_q, key: key_q, year: year_q};
	assign lt    = lt_q;
	assign eq    = eq_q;

endmodule

// ===== hw/rtl/sorted_key_table.sv =====
// Sorted key table: up to CAPACITY entries of key and year held in ascending
// key order in a row of cells. Each transfer is an insert or a delete and
// yields one result with status, entry count, min/max key and empty flag.
// The transfer registers the command; then every cell compares its key in
// parallel, the row shifts by one slot, and the output register is loaded.
// A new item is taken only once the sequencer is back in idle, and then at
// once, even while the previous result still waits in the output register;
// a result that cannot be loaded holds the sequencer in its result state.
module sorted_key_table #(
	parameter int CAPACITY = 16
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 in_valid,
	output logic                                 in_ready,
	input  logic                                 func,
	input  logic [skt_pkg::KEY_W-1:0]            key_id,
	input  logic [skt_pkg::YEAR_W-1:0]           year,
	output logic                                 out_valid,
	input  logic                                 out_ready,
	output logic [skt_pkg::STATUS_W-1:0]         status,
	output logic [skt_pkg::ENTRY_COUNT_W-1:0]    entry_count,
	output logic [skt_pkg::KEY_W-1:0]            min_key,
	output logic [skt_pkg::KEY_W-1:0]            max_key,
	output logic                                 is_empty
);

	localparam int CNT_W = $clog2(CAPACITY + 1);

	typedef enum logic [3:0] {
		S_IDLE = 4'b0001,
		S_CMP  = 4'b0010,
		S_UPD  = 4'b0100,
		S_RES  = 4'b1000
	} state_t;

	state_t                     state_q;
	skt_pkg::func_t             func_q;
	logic [skt_pkg::KEY_W-1:0]  key_q;
	logic [skt_pkg::YEAR_W-1:0] year_q;
	logic [CNT_W-1:0]           count_q;
	skt_pkg::status_t           status_q;

	logic                       out_valid_q;
	skt_pkg::status_t           out_status_q;
	logic [CNT_W-1:0]           out_count_q;
	logic [skt_pkg::KEY_W-1:0]  out_min_q;
	logic [skt_pkg::KEY_W-1:0]  out_max_q;

	skt_pkg::cell_ctrl_t        ctrl;
	skt_pkg::entry_t            cell_entry [CAPACITY];
	logic [CAPACITY-1:0]        lt_vec;
	logic [CAPACITY-1:0]        eq_vec;
	logic [CAPACITY-1:0]        valid_vec;
	logic                       hit;
	logic                       full;
	logic                       do_ins;
	logic                       do_del;
	logic [skt_pkg::KEY_W-1:0]  max_sel;
	logic                       in_xfer;
	logic                       res_load;

	assign in_xfer  = in_valid && in_ready;
	assign in_ready = (state_q == S_IDLE);
	assign res_load = (state_q == S_RES) && (!out_valid_q || out_ready);

	assign hit    = |eq_vec;
	assign full   = valid_vec[CAPACITY-1];
	assign do_ins = (state_q == S_UPD) && (func_q == skt_pkg::FUNC_INSERT) && !hit && !full;
	assign do_del = (state_q == S_UPD) && (func_q == skt_pkg::FUNC_DELETE) && hit;

	assign ctrl = '{cmp_en: (state_q == S_CMP), ins_en: do_ins, del_en: do_del,
		key: key_q, year: year_q};

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		skt_pkg::entry_t left_e;
		skt_pkg::entry_t right_e;
		logic            left_l;

		if (i == 0) begin : g_first
			assign left_e = '0;
			assign left_l = 1'b1;
		end else begin : g_mid_l
			assign left_e = cell_entry[i-1];
			assign left_l = lt_vec[i-1];
		end
		if (i == CAPACITY - 1) begin : g_last
			assign right_e = '0;
		end else begin : g_mid_r
			assign right_e = cell_entry[i+1];
		end

		skt_cell u_cell (
			.clk         (clk),
			.arst_n      (arst_n),
			.ctrl        (ctrl),
			.left_entry  (left_e),
			.left_lt     (left_l),
			.right_entry (right_e),
			.entry       (cell_entry[i]),
			.lt          (lt_vec[i]),
			.eq          (eq_vec[i])
		);

		assign valid_vec[i] = cell_entry[i].valid;
	end

	// last valid cell holds the largest key
	always_comb begin
		max_sel = '0;
		for (int i = 0; i < CAPACITY; i++) begin
			if (valid_vec[i] && ((i == CAPACITY - 1) || !valid_vec[(i + 1) % CAPACITY])) begin
				max_sel = max_sel | cell_entry[i].key;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: if (in_xfer) state_q <= S_CMP;
				S_CMP:  state_q <= S_UPD;
				S_UPD: begin
					state_q <= S_RES;
					if (do_ins) begin
						count_q <= count_q + CNT_W'(1);
					end else if (do_del) begin
						count_q <= count_q - CNT_W'(1);
					end
				end
				S_RES:  if (res_load) state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
			if (res_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			func_q <= skt_pkg::func_t'(func);
			key_q  <= key_id;
			year_q <= year;
		end
		if (state_q == S_UPD) begin
			priority if (func_q == skt_pkg::FUNC_INSERT) begin
				status_q <= hit ? skt_pkg::ST_DUPLICATE :
					(full ? skt_pkg::ST_FULL : skt_pkg::ST_INSERTED);
			end else begin
				status_q <= hit ? skt_pkg::ST_REMOVED : skt_pkg::ST_NOT_FOUND;
			end
		end
		if (res_load) begin
			out_status_q <= status_q;
			out_count_q  <= count_q;
			out_min_q    <= valid_vec[0] ? cell_entry[0].key : '0;
			out_max_q    <= max_sel;
		end
	end

	assign out_valid   = out_valid_q;
	assign status      = out_status_q;
	assign entry_count = skt_pkg::ENTRY_COUNT_W'(out_count_q);
	assign min_key     = out_min_q;
	assign max_key     = out_max_q;
	assign is_empty    = (out_count_q == '0);

`ifndef SYNTHESIS
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(CAPACITY))
		else $error("entry count beyond capacity");

	a_valid_matches_count: assert property (@(posedge clk) disable iff (!arst_n)
		$countones(valid_vec) == int'(count_q))
		else $error("valid cells disagree with count");

	a_valid_prefix: assert property (@(posedge clk) disable iff (!arst_n)
		((valid_vec + CAPACITY'(1)) & valid_vec) == '0)
		else $error("valid cells not contiguous from slot zero");

	a_result_from_res: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == S_RES))
		else $error("result loaded outside result state");

	a_delete_count: assert property (@(posedge clk) disable iff (!arst_n)
		do_del |=> count_q == $past(count_q) - CNT_W'(1))
		else $error("delete did not reduce count");
`endif

endmodule

// ===== bench/sorted_key_table_test.sv =====
module sorted_key_table_test;
	timeunit 1ns;
	timeprecision 1ps;

	import skt_pkg::*;

	localparam int CAPACITY   = 16;
	localparam int IDLE_LIMIT = 5000;
	localparam int PHASE_CMDS = 425;

	typedef struct {
		func_t             f;
		logic [KEY_W-1:0]  k;
		logic [YEAR_W-1:0] y;
	} command_t;

	typedef struct {
		status_t                  st;
		logic [ENTRY_COUNT_W-1:0] cnt;
		logic [KEY_W-1:0]         lo;
		logic [KEY_W-1:0]         hi;
		logic                     empty;
	} table_result_t;

	logic                     clk = 1'b0;
	logic                     arst_n = 1'b0;
	logic                     in_valid = 1'b0;
	logic                     in_ready;
	logic                     func = 1'b0;
	logic [KEY_W-1:0]         key_id = '0;
	logic [YEAR_W-1:0]        year = '0;
	logic                     out_valid;
	logic                     out_ready = 1'b0;
	logic [STATUS_W-1:0]      status;
	logic [ENTRY_COUNT_W-1:0] entry_count;
	logic [KEY_W-1:0]         min_key;
	logic [KEY_W-1:0]         max_key;
	logic                     is_empty;

	command_t         pending_commands[$];
	table_result_t    pending_results[$];
	logic [KEY_W-1:0] live_keys[$];
	command_t         next_cmd;
	logic             in_taken = 1'b0;
	int               send_idle_pct = 0;
	int               stall_pct = 0;
	int               idle_cycles = 0;
	int               mismatches = 0;

	logic [KEY_W-1:0]  table_key[CAPACITY];
	logic [YEAR_W-1:0] table_year[CAPACITY];
	int                table_count = 0;

	sorted_key_table #(
		.CAPACITY(CAPACITY)
	) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.func(func),
		.key_id(key_id),
		.year(year),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.status(status),
		.entry_count(entry_count),
		.min_key(min_key),
		.max_key(max_key),
		.is_empty(is_empty)
	);

	always #5 clk = ~clk;

	// sorted insert/delete on the shadow table, result after the command
	function automatic table_result_t apply_command(func_t f, logic [KEY_W-1:0] k,
			logic [YEAR_W-1:0] y);
		table_result_t r;
		int pos;
		int i;
		bit hit;
		pos = 0;
		while (pos < table_count && table_key[pos] < k)
			pos++;
		hit = (pos < table_count) && (table_key[pos] == k);
		if (f == FUNC_INSERT) begin
			if (hit) begin
				r.st = ST_DUPLICATE;
			end else if (table_count >= CAPACITY) begin
				r.st = ST_FULL;
			end else begin
				for (i = table_count; i > pos; i--) begin
					table_key[i]  = table_key[i-1];
					table_year[i] = table_year[i-1];
				end
				table_key[pos]  = k;
				table_year[pos] = y;
				table_count++;
				r.st = ST_INSERTED;
			end
		end else begin
			if (!hit) begin
				r.st = ST_NOT_FOUND;
			end else begin
				for (i = pos; i + 1 < table_count; i++) begin
					table_key[i]  = table_key[i+1];
					table_year[i] = table_year[i+1];
				end
				table_count--;
				r.st = ST_REMOVED;
			end
		end
		r.cnt   = ENTRY_COUNT_W'(table_count);
		r.empty = (table_count == 0);
		r.lo    = r.empty ? '0 : table_key[0];
		r.hi    = r.empty ? '0 : table_key[table_count-1];
		return r;
	endfunction

	function automatic logic [KEY_W-1:0] pick_key();
		if ($urandom_range(9, 0) == 0)
			return $urandom_range(1, 0) ? {KEY_W{1'b1}} : '0;
		return KEY_W'($urandom);
	endfunction

	// live_keys tracks membership only, so deletes can target held keys
	task automatic queue_command(func_t f, logic [KEY_W-1:0] k, logic [YEAR_W-1:0] y);
		int slot;
		command_t c;
		slot = -1;
		foreach (live_keys[i])
			if (live_keys[i] == k)
				slot = i;
		if (f == FUNC_INSERT && slot < 0 && live_keys.size() < CAPACITY)
			live_keys.push_back(k);
		if (f == FUNC_DELETE && slot >= 0)
			live_keys.delete(slot);
		c.f = f;
		c.k = k;
		c.y = y;
		pending_commands.push_back(c);
	endtask

	task automatic queue_random_commands(int n);
		int queued;
		int burst;
		int ins_pct;
		logic [KEY_W-1:0] k;
		queued = 0;
		while (queued < n) begin
			case ($urandom_range(3, 0))
				0: ins_pct = 20;
				1: ins_pct = 50;
				2: ins_pct = 75;
				default: ins_pct = 92;
			endcase
			burst = $urandom_range(60, 10);
			repeat (burst) begin
				if ($urandom_range(99, 0) < ins_pct) begin
					if (live_keys.size() != 0 && $urandom_range(99, 0) < 15)
						k = live_keys[$urandom_range(live_keys.size() - 1, 0)];
					else
						k = pick_key();
					queue_command(FUNC_INSERT, k, YEAR_W'($urandom));
				end else begin
					if (live_keys.size() != 0 && $urandom_range(99, 0) < 80)
						k = live_keys[$urandom_range(live_keys.size() - 1, 0)];
					else
						k = pick_key();
					queue_command(FUNC_DELETE, k, YEAR_W'($urandom));
				end
			end
			queued += burst;
		end
	endtask

	task automatic report_mismatch(string field_name, int got, int want);
		mismatches++;
		if (mismatches <= 100)
			$display("%0t: %s mismatch, got %0d expected %0d", $realtime, field_name,
				got, want);
	endtask

	task automatic wait_drained();
		while (pending_commands.size() != 0 || in_valid || pending_results.size() != 0)
			@(posedge clk);
	endtask

	// driver
	always @(negedge clk) begin
		if (arst_n && (!in_valid || in_taken)) begin
			if (pending_commands.size() != 0 && $urandom_range(99, 0) >= send_idle_pct) begin
				next_cmd = pending_commands.pop_front();
				in_valid <= 1'b1;
				func     <= next_cmd.f;
				key_id   <= next_cmd.k;
				year     <= next_cmd.y;
			end else begin
				in_valid <= 1'b0;
			end
		end
		out_ready <= arst_n && ($urandom_range(99, 0) >= stall_pct);
	end

	// monitor
	always @(posedge clk) begin
		table_result_t want;
		in_taken <= in_valid && in_ready;
		if (in_valid && in_ready)
			pending_results.push_back(apply_command(func_t'(func), key_id, year));
		if (out_valid && out_ready) begin
			if (pending_results.size() == 0) begin
				report_mismatch("unexpected transfer, status", status, -1);
			end else begin
				want = pending_results.pop_front();
				if (status !== want.st)
					report_mismatch("status", status, want.st);
				if (entry_count !== want.cnt)
					report_mismatch("entry_count", entry_count, want.cnt);
				if (min_key !== want.lo)
					report_mismatch("min_key", min_key, want.lo);
				if (max_key !== want.hi)
					report_mismatch("max_key", max_key, want.hi);
				if (is_empty !== want.empty)
					report_mismatch("is_empty", is_empty, want.empty);
			end
		end
		if ((in_valid && in_ready) || (out_valid && out_ready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= IDLE_LIMIT) begin
			$display("sorted_key_table regression: fail");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	initial begin
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// empty table, extremes, duplicates
		queue_command(FUNC_DELETE, 16'h1234, 12'h000);
		queue_command(FUNC_INSERT, 16'h0000, 12'h000);
		queue_command(FUNC_INSERT, 16'hFFFF, 12'hFFF);
		queue_command(FUNC_INSERT, 16'h0000, 12'h555);
		queue_command(FUNC_DELETE, 16'hFFFF, 12'hAAA);
		queue_command(FUNC_DELETE, 16'h0000, 12'hFFF);
		queue_command(FUNC_DELETE, 16'h0000, 12'h000);
		// fill in ascending key order, then hit the full table
		for (int i = 0; i < CAPACITY - 1; i++)
			queue_command(FUNC_INSERT, KEY_W'(i * 4111 + 37 * i * i), YEAR_W'(i * 273));
		queue_command(FUNC_INSERT, 16'hFFFF, 12'hFFF);
		queue_command(FUNC_INSERT, 16'h8001, 12'h123);
		queue_command(FUNC_INSERT, KEY_W'(7 * 4111 + 37 * 49), 12'h321);
		queue_command(FUNC_DELETE, 16'h7777, 12'h000);

		queue_random_commands(PHASE_CMDS);
		wait_drained();

		send_idle_pct = 53;
		stall_pct     = 0;
		queue_random_commands(PHASE_CMDS);
		wait_drained();

		send_idle_pct = 0;
		stall_pct     = 53;
		queue_random_commands(PHASE_CMDS);
		wait_drained();

		send_idle_pct = 6;
		stall_pct     = 6;
		queue_random_commands(PHASE_CMDS);
		wait_drained();

		repeat (12) @(posedge clk);
		if (mismatches == 0)
			$display("sorted_key_table regression: pass");
		else
			$display("sorted_key_table regression: fail");
		$finish;
	end

endmodule

// ===== files.f =====
hw/rtl/skt_pkg.sv
hw/rtl/skt_cell.sv
hw/rtl/sorted_key_table.sv
bench/sorted_key_table_test.sv
